// ===== rtl/pvkf_pkg.sv =====
// pvkf_pkg: shared types and constants of the position/velocity Kalman filter.
// No dependencies; used by the channel interfaces, the serial unit and the top level.
package pvkf_pkg;

  localparam int IO_BITS  = 48;
  localparam int CFG_BITS = 47;
  localparam int DT_BITS  = 33;
  localparam int IDX_BITS = 2;

  localparam logic [IDX_BITS-1:0] REG_Q_POSITION    = 2'd0;
  localparam logic [IDX_BITS-1:0] REG_Q_VELOCITY    = 2'd1;
  localparam logic [IDX_BITS-1:0] REG_MEAS_NOISE    = 2'd2;
  localparam logic [IDX_BITS-1:0] REG_SAMPLE_PERIOD = 2'd3;

  typedef logic [IO_BITS-1:0] io_word_t;

  localparam logic OP_MUL = 1'b0;
  localparam logic OP_DIV = 1'b1;

  typedef struct packed {
    logic start;
    logic op;
  } unit_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

endpackage

// ===== rtl/pvkf_if.sv =====
// pvkf_in_if / pvkf_out_if: valid/ready channels of the filter.
// Depends on pvkf_pkg for the field type.
interface pvkf_in_if import pvkf_pkg::*; ();
  logic     valid;
  logic     ready;
  io_word_t measured_position;
  io_word_t accel;
  modport source (output valid, output measured_position, output accel, input ready);
  modport sink   (input valid, input measured_position, input accel, output ready);
endinterface

interface pvkf_out_if import pvkf_pkg::*; ();
  logic     valid;
  logic     ready;
  io_word_t est_position;
  io_word_t est_velocity;
  modport source (output valid, output est_position, output est_velocity, input ready);
  modport sink   (input valid, input est_position, input est_velocity, output ready);
endinterface

// ===== rtl/pvkf_serial_unit.sv =====
// pvkf_serial_unit: bit-serial saturating fixed-point multiply and divide.
// Depends on pvkf_pkg; one operation at a time, one bit per cycle.
module pvkf_serial_unit import pvkf_pkg::*; #(
  parameter int WORD_BITS = 48,
  parameter int FRAC_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  unit_ctl_t                   ctl,
  input  logic signed [WORD_BITS-1:0] op_a,
  input  logic signed [WORD_BITS-1:0] op_b,
  output unit_sts_t                   sts,
  output logic signed [WORD_BITS-1:0] res
);

  localparam int W   = WORD_BITS;
  localparam int F   = FRAC_BITS;
  localparam int MIT = (W > F) ? W : F;
  localparam int DW  = W + F;
  localparam int PW  = W + MIT;
  localparam int CW  = $clog2(DW + 1);

  localparam logic [1:0] U_IDLE = 2'd0;
  localparam logic [1:0] U_MUL  = 2'd1;
  localparam logic [1:0] U_DIV  = 2'd2;
  localparam logic [1:0] U_FIN  = 2'd3;

  logic [1:0]    state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          neg_r, neg_nxt;
  logic          op_r, op_nxt;
  logic          dz_r, dz_nxt;
  logic [W-1:0]  x_r, x_nxt;      // multiplicand or divisor magnitude
  logic [W-1:0]  y_r, y_nxt;      // multiplier bits, lsb first
  logic [W-1:0]  acc_r, acc_nxt;  // product high part or remainder
  logic [MIT-1:0] lo_r, lo_nxt;
  logic [DW-1:0] dsh_r, dsh_nxt;  // numerator out, quotient in

  logic [W-1:0]    mag_a, mag_b;
  logic [W:0]      msum;
  logic [W:0]      rr;
  logic            ge;
  logic [PW-1:0]   prod;
  logic [PW-F-1:0] pm;
  logic            ovf;
  logic [W-1:0]    m;
  logic [W-1:0]    wmax;

  assign mag_a = op_a[W-1] ? (~op_a + 1'b1) : op_a;
  assign mag_b = op_b[W-1] ? (~op_b + 1'b1) : op_b;
  assign msum  = {1'b0, acc_r} + (y_r[0] ? {1'b0, x_r} : {(W+1){1'b0}})
               + {{W{1'b0}}, (cnt_r == CW'(F - 1))};
  assign rr    = {acc_r, dsh_r[DW-1]};
  assign ge    = rr >= {1'b0, x_r};
  assign prod  = {acc_r, lo_r};
  assign pm    = prod[PW-1:F];
  assign wmax  = {1'b0, {(W-1){1'b1}}};

  always_comb begin
    if (op_r == OP_MUL) begin
      ovf = |pm[PW-F-1:W-1];
      m   = pm[W-1:0];
    end else begin
      ovf = |dsh_r[DW-1:W-1];
      m   = dsh_r[W-1:0];
    end
    if (op_r == OP_DIV && dz_r) begin
      res = '0;
    end else if (ovf) begin
      res = neg_r ? ~wmax : wmax;
    end else begin
      res = neg_r ? (~m + 1'b1) : m;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    neg_nxt   = neg_r;
    op_nxt    = op_r;
    dz_nxt    = dz_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    acc_nxt   = acc_r;
    lo_nxt    = lo_r;
    dsh_nxt   = dsh_r;
    unique case (state_r)
      U_IDLE: begin
        if (ctl.start) begin
          op_nxt  = ctl.op;
          neg_nxt = op_a[W-1] ^ op_b[W-1];
          cnt_nxt = '0;
          acc_nxt = '0;
          lo_nxt  = '0;
          dz_nxt  = (mag_b == '0);
          if (ctl.op == OP_MUL) begin
            x_nxt     = mag_a;
            y_nxt     = mag_b;
            state_nxt = U_MUL;
          end else begin
            x_nxt     = mag_b;
            dsh_nxt   = {mag_a, {F{1'b0}}};
            state_nxt = U_DIV;
          end
        end
      end
      U_MUL: begin
        acc_nxt = msum[W:1];
        lo_nxt  = {msum[0], lo_r[MIT-1:1]};
        y_nxt   = {1'b0, y_r[W-1:1]};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CW'(MIT - 1)) state_nxt = U_FIN;
      end
      U_DIV: begin
        acc_nxt = ge ? W'(rr - {1'b0, x_r}) : rr[W-1:0];
        dsh_nxt = {dsh_r[DW-2:0], ge};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CW'(DW - 1)) state_nxt = U_FIN;
      end
      U_FIN: state_nxt = U_IDLE;
      default: state_nxt = U_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= U_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    cnt_r <= cnt_nxt;
    neg_r <= neg_nxt;
    op_r  <= op_nxt;
    dz_r  <= dz_nxt;
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    acc_r <= acc_nxt;
    lo_r  <= lo_nxt;
    dsh_r <= dsh_nxt;
  end

  assign sts.busy = (state_r != U_IDLE);
  assign sts.done = (state_r == U_FIN);

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.start |-> state_r == U_IDLE) else $error("start while unit busy");
  a_fin_once: assert property (@(posedge clk) disable iff (!rst_n)
    sts.done |=> !sts.done) else $error("done held for two cycles");
  a_mul_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == U_MUL) |-> cnt_r < CW'(MIT)) else $error("multiply overran");

endmodule

// ===== rtl/position_velocity_kalman_filter.sv =====
// position_velocity_kalman_filter: top level, step sequencer and filter state.
// Depends on pvkf_pkg, pvkf_if and pvkf_serial_unit.
//
//  channel   dir  handshake     payload
//  in_chan   in   valid/ready   measured_position, accel
//  out_chan  out  valid/ready   est_position, est_velocity
//  cfg_*     in   wr_en only    cfg_index, cfg_data
//
// An item runs 16 steps on one bit-serial multiply/divide unit: 12 multiplies,
// 2 divides and 2 add steps, each step passing through the issue, wait (not for the
// add steps) and post states, between the accept in idle and the hold state.
// in_chan.ready is high while no item is in work; a result waits in the output register.
// A stalled output holds the finished item in the last step. Reset is synchronous.
module position_velocity_kalman_filter import pvkf_pkg::*; #(
  parameter int WORD_BITS = 48,
  parameter int FRAC_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  pvkf_in_if.sink             in_chan,
  pvkf_out_if.source          out_chan,
  input  logic                cfg_wr_en,
  input  logic [IDX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0] cfg_data
);

  localparam int W = WORD_BITS;
  localparam logic [64:0] WMAX65 = (65'd1 << (W - 1)) - 65'd1;
  localparam logic [64:0] ONE65  = 65'd1 << FRAC_BITS;
  localparam logic [64:0] DT65   = (ONE65 + 65'd250) / 65'd500;
  localparam logic [64:0] OMAX65 = (65'd1 << (IO_BITS - 1)) - 65'd1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ISSUE = 3'd1;
  localparam logic [2:0] S_WAIT  = 3'd2;
  localparam logic [2:0] S_POST  = 3'd3;
  localparam logic [2:0] S_HOLD  = 3'd4;

  localparam logic [3:0] ST_HALF_DT2 = 4'd0;
  localparam logic [3:0] ST_XP_V     = 4'd1;
  localparam logic [3:0] ST_XP_A     = 4'd2;
  localparam logic [3:0] ST_VP       = 4'd3;
  localparam logic [3:0] ST_S0       = 4'd4;
  localparam logic [3:0] ST_S1       = 4'd5;
  localparam logic [3:0] ST_S0_S1    = 4'd6;
  localparam logic [3:0] ST_QADD     = 4'd7;
  localparam logic [3:0] ST_DEN      = 4'd8;
  localparam logic [3:0] ST_K0       = 4'd9;
  localparam logic [3:0] ST_K1       = 4'd10;
  localparam logic [3:0] ST_POS      = 4'd11;
  localparam logic [3:0] ST_VEL      = 4'd12;
  localparam logic [3:0] ST_P00      = 4'd13;
  localparam logic [3:0] ST_P01      = 4'd14;
  localparam logic [3:0] ST_P11      = 4'd15;

  typedef logic signed [W-1:0] word_t;

  function automatic word_t sadd(word_t a, word_t b);
    logic [W:0] s;
    s = {a[W-1], a} + {b[W-1], b};
    if (s[W] != s[W-1]) return s[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    return s[W-1:0];
  endfunction

  function automatic word_t ssub(word_t a, word_t b);
    logic [W:0] s;
    s = {a[W-1], a} - {b[W-1], b};
    if (s[W] != s[W-1]) return s[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    return s[W-1:0];
  endfunction

  function automatic word_t clamp_u(logic [64:0] v);
    if (v > WMAX65) return WMAX65[W-1:0];
    return v[W-1:0];
  endfunction

  function automatic word_t from_io(io_word_t v);
    logic signed [64:0] s;
    s = {{(65-IO_BITS){v[IO_BITS-1]}}, v};
    if (s > $signed(WMAX65)) return WMAX65[W-1:0];
    if (s < -$signed(WMAX65) - 65'sd1) return ~WMAX65[W-1:0];
    return s[W-1:0];
  endfunction

  function automatic io_word_t to_io(word_t v);
    logic signed [64:0] s;
    s = {{(65-W){v[W-1]}}, v};
    if (s > $signed(OMAX65)) return OMAX65[IO_BITS-1:0];
    if (s < -$signed(OMAX65) - 65'sd1) return ~OMAX65[IO_BITS-1:0];
    return s[IO_BITS-1:0];
  endfunction

  logic [CFG_BITS-1:0] q_pos_r, q_vel_r, r_noise_r;
  logic [DT_BITS-1:0]  dt_reg_r;

  logic [2:0] state_r, state_nxt;
  logic [3:0] step_r, step_nxt;
  word_t x_r, v_r, p00_r, p01_r, p11_r;
  word_t z_r, a_r, h_r, xp_r, vp_r, s0_r, s1_r, pp11_r, den_r, e_r, k0_r, k1_r, res_r;
  logic      out_valid_r;
  io_word_t  out_pos_r, out_vel_r;

  word_t     dt, ua, ub, res;
  unit_ctl_t ctl;
  unit_sts_t sts;
  logic      is_nop;

  assign dt = clamp_u({{(65-DT_BITS){1'b0}}, dt_reg_r});

  always_comb begin
    ua     = dt;
    ub     = dt;
    ctl.op = OP_MUL;
    is_nop = 1'b0;
    unique case (step_r) inside
      ST_HALF_DT2: ub = dt;
      ST_XP_V:     ub = v_r;
      ST_XP_A:     begin ua = h_r; ub = a_r; end
      ST_VP:       ub = a_r;
      ST_S0:       ub = p01_r;
      ST_S1:       ub = p11_r;
      ST_S0_S1:    ub = s1_r;
      ST_QADD, ST_DEN: is_nop = 1'b1;
      ST_K0:       begin ua = s0_r; ub = den_r; ctl.op = OP_DIV; end
      ST_K1:       begin ua = s1_r; ub = den_r; ctl.op = OP_DIV; end
      ST_POS:      begin ua = k0_r; ub = e_r; end
      ST_VEL:      begin ua = k1_r; ub = e_r; end
      ST_P00:      begin ua = k0_r; ub = s0_r; end
      ST_P01:      begin ua = k0_r; ub = s1_r; end
      ST_P11:      begin ua = k1_r; ub = s1_r; end
      default:     is_nop = 1'b1;
    endcase
    ctl.start = (state_r == S_ISSUE) && !is_nop;
  end

  pvkf_serial_unit #(.WORD_BITS(W), .FRAC_BITS(FRAC_BITS)) u_unit (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .op_a  (ua),
    .op_b  (ub),
    .sts   (sts),
    .res   (res)
  );

  assign in_chan.ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    unique case (state_r)
      S_IDLE:  if (in_chan.valid) begin state_nxt = S_ISSUE; step_nxt = ST_HALF_DT2; end
      S_ISSUE: state_nxt = is_nop ? S_POST : S_WAIT;
      S_WAIT:  if (sts.done) state_nxt = S_POST;
      S_POST: begin
        if (step_r == ST_P11) begin
          state_nxt = S_HOLD;
        end else begin
          step_nxt  = step_r + 4'd1;
          state_nxt = S_ISSUE;
        end
      end
      S_HOLD:  if (!out_valid_r || out_chan.ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= ST_HALF_DT2;
      out_valid_r <= 1'b0;
      q_pos_r     <= '0;
      q_vel_r     <= '0;
      r_noise_r   <= ONE65[CFG_BITS-1:0];
      dt_reg_r    <= DT65[DT_BITS-1:0];
      x_r         <= '0;
      v_r         <= '0;
      p00_r       <= clamp_u(ONE65);
      p01_r       <= '0;
      p11_r       <= clamp_u(ONE65);
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      if (cfg_wr_en) begin
        unique case (cfg_index)
          REG_Q_POSITION:    q_pos_r   <= cfg_data;
          REG_Q_VELOCITY:    q_vel_r   <= cfg_data;
          REG_MEAS_NOISE:    r_noise_r <= cfg_data;
          REG_SAMPLE_PERIOD: dt_reg_r  <= cfg_data[DT_BITS-1:0];
          default: ;
        endcase
      end
      if (state_r == S_POST) begin
        case (step_r)
          ST_POS: x_r   <= sadd(xp_r, res_r);
          ST_VEL: v_r   <= sadd(vp_r, res_r);
          ST_P00: p00_r <= ssub(s0_r, res_r);
          ST_P01: p01_r <= ssub(s1_r, res_r);
          ST_P11: p11_r <= ssub(pp11_r, res_r);
          default: ;
        endcase
      end
      if (state_r == S_HOLD && state_nxt == S_IDLE) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      z_r <= from_io(in_chan.measured_position);
      a_r <= from_io(in_chan.accel);
    end
    if (sts.done) res_r <= res;
    if (state_r == S_POST) begin
      case (step_r)
        ST_HALF_DT2: h_r  <= res_r >>> 1;
        ST_XP_V:     xp_r <= sadd(x_r, res_r);
        ST_XP_A:     xp_r <= sadd(xp_r, res_r);
        ST_VP:       vp_r <= sadd(v_r, res_r);
        ST_S0:       s0_r <= sadd(p00_r, res_r);
        ST_S1:       s1_r <= sadd(p01_r, res_r);
        ST_S0_S1:    s0_r <= sadd(s0_r, res_r);
        ST_QADD: begin
          s0_r   <= sadd(s0_r, clamp_u({{(65-CFG_BITS){1'b0}}, q_pos_r}));
          pp11_r <= sadd(p11_r, clamp_u({{(65-CFG_BITS){1'b0}}, q_vel_r}));
        end
        ST_DEN: begin
          den_r <= sadd(s0_r, clamp_u({{(65-CFG_BITS){1'b0}}, r_noise_r}));
          e_r   <= ssub(z_r, xp_r);
        end
        ST_K0:       k0_r <= res_r;
        ST_K1:       k1_r <= res_r;
        default: ;
      endcase
    end
    if (state_r == S_HOLD && state_nxt == S_IDLE) begin
      out_pos_r <= to_io(x_r);
      out_vel_r <= to_io(v_r);
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.est_position = out_pos_r;
  assign out_chan.est_velocity = out_vel_r;

  a_idle_unit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !sts.busy) else $error("unit busy with no item in work");
  a_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    sts.done |-> state_r == S_WAIT) else $error("unit result outside wait");
  a_accept_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |=> (state_r == S_ISSUE && step_r == ST_HALF_DT2))
    else $error("item accepted without starting the sequence");
  a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_HOLD && out_valid_r && !out_chan.ready) |=> state_r == S_HOLD)
    else $error("result overwritten while stalled");

endmodule

// ===== sim/pvkf_tb_if.sv =====
`timescale 1ns / 100ps
// Testbench-side notes for the filter channels: the channel interfaces come from
// rtl/pvkf_if.sv and are instanced directly by the testbench top.
// Depends on pvkf_pkg; holds only the shared item, result and stimulus structs.
package pvkf_tb_pkg;
  import pvkf_pkg::*;

  typedef struct packed {
    io_word_t measured_position;
    io_word_t accel;
  } meas_item_t;

  typedef struct packed {
    io_word_t est_position;
    io_word_t est_velocity;
  } estimate_t;

  typedef struct packed {
    logic                is_cfg;
    logic [IDX_BITS-1:0] index;
    logic [CFG_BITS-1:0] data;
    meas_item_t          meas;
    logic                drain;
  } stim_t;
endpackage

// ===== sim/position_velocity_kalman_filter_tb.sv =====
`timescale 1ns / 100ps
// Testbench of position_velocity_kalman_filter: drives measurements and register
// writes, predicts the estimates in fixed point and compares each transfer.
// Depends on pvkf_pkg, pvkf_if, pvkf_tb_pkg and the filter RTL.
module position_velocity_kalman_filter_tb;
  import pvkf_pkg::*;
  import pvkf_tb_pkg::*;

  localparam longint WMAX = 64'sd140737488355327;
  localparam longint WMIN = -64'sd140737488355328;
  localparam longint ONE = 64'sd4294967296;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [IDX_BITS-1:0] cfg_index = '0;
  logic [CFG_BITS-1:0] cfg_data = '0;

  pvkf_in_if in_chan ();
  pvkf_out_if out_chan ();

  position_velocity_kalman_filter dut (
    .clk(clk), .rst_n(rst_n), .in_chan(in_chan.sink), .out_chan(out_chan.source),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  stim_t stim_q[$];
  estimate_t est_q[$];
  int mismatches = 0;
  bit stim_done = 1'b0;
  bit in_acc = 1'b0;
  bit out_acc = 1'b0;
  bit cfg_fire = 1'b0;

  longint unsigned q_pos, q_vel, r_noise, dt_reg;
  longint pos_s, vel_s, p00_s, p01_s, p11_s;

  function automatic longint sat(logic signed [129:0] v);
    if (v > WMAX) return WMAX;
    if (v < WMIN) return WMIN;
    return longint'(v);
  endfunction

  function automatic longint sadd(longint a, longint b);
    return sat(130'(signed'(a)) + 130'(signed'(b)));
  endfunction

  function automatic longint ssub(longint a, longint b);
    return sat(130'(signed'(a)) - 130'(signed'(b)));
  endfunction

  function automatic longint fmul(longint a, longint b);
    logic [129:0] m;
    logic signed [129:0] r;
    m = 130'(a < 0 ? -a : a) * 130'(b < 0 ? -b : b);
    m = (m + (130'd1 << 31)) >> 32;
    r = ((a < 0) != (b < 0)) ? -$signed(m) : $signed(m);
    return sat(r);
  endfunction

  function automatic longint fdiv(longint n, longint d);
    logic [129:0] q;
    logic signed [129:0] r;
    if (d == 0) return 0;
    q = (130'(n < 0 ? -n : n) << 32) / 130'(d < 0 ? -d : d);
    r = ((n < 0) != (d < 0)) ? -$signed(q) : $signed(q);
    return sat(r);
  endfunction

  function automatic longint clamp_reg(longint unsigned v);
    return (v > WMAX) ? WMAX : longint'(v);
  endfunction

  function automatic void reset_filter();
    q_pos = 0; q_vel = 0; r_noise = ONE; dt_reg = 64'd8589935;
    pos_s = 0; vel_s = 0; p00_s = ONE; p01_s = 0; p11_s = ONE;
  endfunction

  function automatic void write_reg(logic [IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] d);
    case (idx)
      REG_Q_POSITION: q_pos = 64'(d);
      REG_Q_VELOCITY: q_vel = 64'(d);
      REG_MEAS_NOISE: r_noise = 64'(d);
      REG_SAMPLE_PERIOD: dt_reg = 64'(d[DT_BITS-1:0]);
      default: ;
    endcase
  endfunction

  function automatic estimate_t filter_step(meas_item_t m);
    longint z, a, dt, hdt2, xp, vp, s0, s1, p00, p01, p11, den, k0, k1, e;
    estimate_t r;
    z = longint'(signed'(m.measured_position));
    a = longint'(signed'(m.accel));
    dt = clamp_reg(dt_reg);
    hdt2 = fmul(dt, dt) >>> 1;
    xp = sadd(sadd(pos_s, fmul(dt, vel_s)), fmul(hdt2, a));
    vp = sadd(vel_s, fmul(dt, a));
    s0 = sadd(p00_s, fmul(dt, p01_s));
    s1 = sadd(p01_s, fmul(dt, p11_s));
    p00 = sadd(sadd(s0, fmul(dt, s1)), clamp_reg(q_pos));
    p01 = s1;
    p11 = sadd(p11_s, clamp_reg(q_vel));
    den = sadd(p00, clamp_reg(r_noise));
    k0 = fdiv(p00, den);
    k1 = fdiv(p01, den);
    e = ssub(z, xp);
    pos_s = sadd(xp, fmul(k0, e));
    vel_s = sadd(vp, fmul(k1, e));
    p00_s = ssub(p00, fmul(k0, p00));
    p01_s = ssub(p01, fmul(k0, p01));
    p11_s = ssub(p11, fmul(k1, p01));
    r.est_position = pos_s[IO_BITS-1:0];
    r.est_velocity = vel_s[IO_BITS-1:0];
    return r;
  endfunction

  initial begin
    forever #1 clk = ~clk;
  end

  // driver
  int send_wait = 0;
  stim_t cur;
  initial begin
    in_chan.valid = 1'b0;
    in_chan.measured_position = '0;
    in_chan.accel = '0;
    out_chan.ready = 1'b0;
  end

  always @(negedge clk) begin
    if (rst_n) begin
      cfg_fire = 1'b0;
      if (in_acc) begin
        in_acc = 1'b0;
        in_chan.valid <= 1'b0;
        send_wait = $urandom_range(0, 3);
      end else if (!in_chan.valid) begin
        if (send_wait > 0) begin
          send_wait--;
        end else if (stim_q.size() > 0) begin
          cur = stim_q[0];
          if (cur.drain || cur.is_cfg) begin
            if (est_q.size() == 0 && !out_chan.valid) begin
              if (cur.drain) begin
                repeat (3000) @(negedge clk);
                void'(stim_q.pop_front());
              end else begin
                cfg_fire = 1'b1;
                cfg_index <= cur.index;
                cfg_data <= cur.data;
                write_reg(cur.index, cur.data);
                void'(stim_q.pop_front());
              end
            end
          end else begin
            void'(stim_q.pop_front());
            in_chan.valid <= 1'b1;
            in_chan.measured_position <= cur.meas.measured_position;
            in_chan.accel <= cur.meas.accel;
            est_q.push_back(filter_step(cur.meas));
          end
        end else begin
          stim_done = 1'b1;
        end
      end
      cfg_wr_en <= cfg_fire;
    end
  end

  // monitor and receiver stalls
  int recv_wait = 0;
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_acc) begin
        out_acc = 1'b0;
        out_chan.ready <= 1'b0;
        recv_wait = $urandom_range(0, 3);
      end else if (recv_wait > 0) begin
        recv_wait--;
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    estimate_t got, want;
    if (rst_n && in_chan.valid && in_chan.ready) in_acc = 1'b1;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      out_acc = 1'b1;
      got.est_position = out_chan.est_position;
      got.est_velocity = out_chan.est_velocity;
      if (est_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transfer %h %h", got.est_position,
                                       got.est_velocity);
      end else begin
        want = est_q.pop_front();
        if (got.est_position !== want.est_position ||
            got.est_velocity !== want.est_velocity) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch pos exp %h got %h vel exp %h got %h",
                     want.est_position, got.est_position,
                     want.est_velocity, got.est_velocity);
        end
      end
    end
  end

  function automatic logic [IO_BITS-1:0] rand_word();
    case ($urandom_range(0, 5))
      0: return {1'b0, {(IO_BITS-1){1'b1}}};
      1: return {1'b1, {(IO_BITS-1){1'b0}}};
      2: return IO_BITS'({$urandom, $urandom});
      default: return IO_BITS'(longint'($urandom_range(0, 200000)) - 100000) <<< 20;
    endcase
  endfunction

  function automatic void add_meas(logic [IO_BITS-1:0] z, logic [IO_BITS-1:0] a);
    stim_t s;
    s = '0;
    s.meas.measured_position = z;
    s.meas.accel = a;
    stim_q.push_back(s);
  endfunction

  function automatic void add_cfg(logic [IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] d);
    stim_t s;
    s = '0;
    s.is_cfg = 1'b1;
    s.index = idx;
    s.data = d;
    stim_q.push_back(s);
  endfunction

  function automatic void add_drain();
    stim_t s;
    s = '0;
    s.drain = 1'b1;
    stim_q.push_back(s);
  endfunction

  initial begin
    logic [IO_BITS-1:0] maxw, minw;
    maxw = {1'b0, {(IO_BITS-1){1'b1}}};
    minw = {1'b1, {(IO_BITS-1){1'b0}}};
    reset_filter();
    add_meas('0, '0);
    add_meas(maxw, maxw);
    add_meas(minw, minw);
    add_meas(maxw, minw);
    add_meas(48'h1_0000_0000, 48'hFFFF_0000_0000);
    add_drain();
    add_cfg(REG_MEAS_NOISE, '0);
    add_cfg(REG_SAMPLE_PERIOD, '0);
    add_meas(48'h5_0000_0000, 48'h2_0000_0000);
    add_meas('0, '0);
    add_drain();
    add_cfg(REG_Q_POSITION, {CFG_BITS{1'b1}});
    add_cfg(REG_Q_VELOCITY, {CFG_BITS{1'b1}});
    add_cfg(REG_MEAS_NOISE, {CFG_BITS{1'b1}});
    add_cfg(REG_SAMPLE_PERIOD, 47'h1_0000_0000);
    add_meas(maxw, maxw);
    add_meas(minw, 48'h1);
    add_meas(48'h1, minw);
    for (int ph = 0; ph < 8; ph++) begin
      add_drain();
      add_cfg(REG_Q_POSITION, ph == 7 ? {CFG_BITS{1'b1}} : CFG_BITS'($urandom_range(0, 1 << 20)));
      add_cfg(REG_Q_VELOCITY, CFG_BITS'({$urandom, $urandom}) >> $urandom_range(0, 46));
      add_cfg(REG_MEAS_NOISE, ph == 0 ? '0 : CFG_BITS'({$urandom, $urandom}) >> $urandom_range(8, 46));
      add_cfg(REG_SAMPLE_PERIOD, ph == 1 ? 47'h1 : CFG_BITS'($urandom_range(1, 1 << 26)));
      if (ph == 3) begin
        add_cfg(REG_SAMPLE_PERIOD, 47'h1_FFFF_FFFF);
      end
      for (int i = 0; i < 48; i++) add_meas(rand_word(), rand_word());
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;
    wait (stim_done);
    while (est_q.size() > 0) @(posedge clk);
    repeat (3000) @(posedge clk);
    if (mismatches == 0 && est_q.size() == 0) begin
      $display("position_velocity_kalman_filter_tb passed");
    end else begin
      $display("position_velocity_kalman_filter_tb failed");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("position_velocity_kalman_filter_tb failed");
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/pvkf_pkg.sv
rtl/pvkf_if.sv
rtl/pvkf_serial_unit.sv
rtl/position_velocity_kalman_filter.sv
sim/pvkf_tb_if.sv
sim/position_velocity_kalman_filter_tb.sv
